### sv/cnaw_pkg.sv
package cnaw_pkg;

  // Default widths of the size accumulators and the entry counter.
  localparam int unsigned SizeBitsDefault       = 32;
  localparam int unsigned EntryCountBitsDefault = 16;

  // Fixed widths of the result fields.
  localparam int unsigned ByteW     = 8;
  localparam int unsigned RegionW   = 3;
  localparam int unsigned EntryOutW = 16;
  localparam int unsigned LengthW   = 32;

  // Header layout of a newc record.
  localparam int unsigned HeaderLen  = 110;
  localparam int unsigned FileSizeAt = 54;
  localparam int unsigned NameSizeAt = 94;
  localparam int unsigned SizeDigits = 8;
  localparam int unsigned HdrPosW    = 7;

  // Trailer name, including its terminating NUL.
  localparam int unsigned TrailerLen = 11;
  localparam int unsigned TrlPosW    = 4;

  // ASCII hex digit decoding, as the archive writer does it.
  localparam int unsigned DigitAlphaStart = 65;
  localparam int unsigned DigitAlphaBias  = 55;
  localparam int unsigned DigitNumBias    = 48;

  // Region tags carried on every result word.
  typedef enum logic [RegionW-1:0] {
    RegionHeader  = 3'd0,
    RegionName    = 3'd1,
    RegionNamePad = 3'd2,
    RegionData    = 3'd3,
    RegionDataPad = 3'd4,
    RegionDone    = 3'd5
  } region_e;

  // Character of the trailer name at a given position.
  function automatic logic [ByteW-1:0] trailer_char(input logic [TrlPosW-1:0] pos);
    logic [ByteW-1:0] ch;
    case (pos)
      4'd0:    ch = 8'h54; // T
      4'd1:    ch = 8'h52; // R
      4'd2:    ch = 8'h41; // A
      4'd3:    ch = 8'h49; // I
      4'd4:    ch = 8'h4C; // L
      4'd5:    ch = 8'h45; // E
      4'd6:    ch = 8'h52; // R
      4'd7:    ch = 8'h21; // !
      4'd8:    ch = 8'h21; // !
      4'd9:    ch = 8'h21; // !
      default: ch = 8'h00; // NUL
    endcase
    return ch;
  endfunction

endpackage

### sv/cpio_newc_archive_walker_unit.sv
// Channel  Direction  Handshake               Payload
// -------  ---------  ----------------------  ----------------------------------------------
// in       input      in_valid_i / in_ready_o archive_byte_i
// out      output     out_valid_o/out_ready_i byte_out_o, region_o, entry_number_o,
//                                             name_length_o, data_length_o, header_done_o,
//                                             trailer_found_o, entry_end_o
//
// One word is accepted per cycle unless the output stalls; its result is then registered.
// The walk state and the result for a word are computed in one pass through the region and
// size logic between the input port and the output register.
// Reset puts the walker at the start of the first header with the entry counter at zero.
// A stalled output holds its word; a new word is still taken in the cycle it is read out.
module cpio_newc_archive_walker_unit import cnaw_pkg::*; #(
  parameter int unsigned SizeBits       = SizeBitsDefault,
  parameter int unsigned EntryCountBits = EntryCountBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ByteW-1:0]     archive_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ByteW-1:0]     byte_out_o,
  output logic [RegionW-1:0]   region_o,
  output logic [EntryOutW-1:0] entry_number_o,
  output logic [LengthW-1:0]   name_length_o,
  output logic [LengthW-1:0]   data_length_o,
  output logic                 header_done_o,
  output logic                 trailer_found_o,
  output logic                 entry_end_o
);

  // Walk state.
  region_e                   region_q, region_d;
  logic [SizeBits-1:0]       left_q, left_d;
  logic [1:0]                ofs_q, ofs_d;
  logic [SizeBits-1:0]       name_acc_q, name_acc_d;
  logic [SizeBits-1:0]       file_acc_q, file_acc_d;
  logic [HdrPosW-1:0]        hdr_pos_q, hdr_pos_d;
  logic [TrlPosW-1:0]        trl_pos_q, trl_pos_d;
  logic                      trl_match_q, trl_match_d;
  logic [EntryCountBits-1:0] entry_q, entry_d;

  // Output register.
  logic                 out_valid_q;
  logic [ByteW-1:0]     byte_q;
  region_e              region_out_q;
  logic [EntryOutW-1:0] entry_out_q;
  logic [LengthW-1:0]   name_len_q;
  logic [LengthW-1:0]   data_len_q;
  logic                 hdone_q, tfound_q, eend_q;

  // Per-word results and helpers.
  logic                accept;
  logic                hdone, tfound, eend;
  logic [SizeBits-1:0] digit;
  logic [SizeBits-1:0] left_dec;
  logic [1:0]          ofs_inc, pad;
  logic                in_file_digits, in_name_digits;
  logic                name_nz, pad_nz, file_nz;
  logic                reach_npad, reach_data, reach_dpad, reach_end;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Hex digit value; non-hex bytes are taken by the same rule and wrap.
  assign digit = (archive_byte_i >= ByteW'(DigitAlphaStart))
               ? SizeBits'(archive_byte_i) - SizeBits'(DigitAlphaBias)
               : SizeBits'(archive_byte_i) - SizeBits'(DigitNumBias);

  assign in_file_digits = (hdr_pos_q >= HdrPosW'(FileSizeAt))
                       && (hdr_pos_q < HdrPosW'(FileSizeAt + SizeDigits));
  assign in_name_digits = (hdr_pos_q >= HdrPosW'(NameSizeAt))
                       && (hdr_pos_q < HdrPosW'(NameSizeAt + SizeDigits));

  assign left_dec = left_q - SizeBits'(1);
  assign ofs_inc  = ofs_q + 2'd1;
  assign pad      = 2'd0 - ofs_inc;

  // Next walk state for the incoming word.
  always_comb begin
    region_d    = region_q;
    left_d      = left_q;
    ofs_d       = ofs_q;
    name_acc_d  = name_acc_q;
    file_acc_d  = file_acc_q;
    hdr_pos_d   = hdr_pos_q;
    trl_pos_d   = trl_pos_q;
    trl_match_d = trl_match_q;
    entry_d     = entry_q;
    hdone       = 1'b0;
    tfound      = 1'b0;
    eend        = 1'b0;

    // Field decoding and trailer matching.
    case (region_q)
      RegionHeader: begin
        if (in_file_digits) begin
          file_acc_d = {file_acc_q[SizeBits-5:0], 4'h0} + digit;
        end
        if (in_name_digits) begin
          name_acc_d = {name_acc_q[SizeBits-5:0], 4'h0} + digit;
        end
        hdr_pos_d = hdr_pos_q + HdrPosW'(1);
      end
      RegionName: begin
        if (trl_match_q && (trl_pos_q < TrlPosW'(TrailerLen))) begin
          if (archive_byte_i != trailer_char(trl_pos_q)) begin
            trl_match_d = 1'b0;
          end else if (trl_pos_q == TrlPosW'(TrailerLen - 1)) begin
            tfound = 1'b1;
          end
        end
        if (trl_pos_q < TrlPosW'(TrailerLen)) begin
          trl_pos_d = trl_pos_q + TrlPosW'(1);
        end
      end
      default: begin
      end
    endcase

    name_nz = name_acc_d != '0;
    file_nz = file_acc_d != '0;
    pad_nz  = pad != 2'd0;

    // Skip over empty regions when the current one runs out.
    reach_npad = ((region_q == RegionHeader) && !name_nz) || (region_q == RegionName);
    reach_data = (reach_npad && !pad_nz) || (region_q == RegionNamePad);
    reach_dpad = (reach_data && !file_nz) || (region_q == RegionData);
    reach_end  = (reach_dpad && !pad_nz) || (region_q == RegionDataPad);

    if (region_q != RegionDone) begin
      left_d = left_dec;
      ofs_d  = ofs_inc;
      if (tfound) begin
        region_d = RegionDone;
      end else if (left_dec == '0) begin
        hdone = region_q == RegionHeader;
        if ((region_q == RegionHeader) && name_nz) begin
          region_d = RegionName;
          left_d   = name_acc_d;
        end else if (reach_npad && pad_nz) begin
          region_d = RegionNamePad;
          left_d   = SizeBits'(pad);
        end else if (reach_data && file_nz) begin
          region_d = RegionData;
          left_d   = file_acc_d;
        end else if (reach_dpad && pad_nz) begin
          region_d = RegionDataPad;
          left_d   = SizeBits'(pad);
        end else if (reach_end) begin
          // Entry finished: start the next header.
          eend        = 1'b1;
          entry_d     = entry_q + EntryCountBits'(1);
          region_d    = RegionHeader;
          left_d      = SizeBits'(HeaderLen);
          ofs_d       = 2'd0;
          name_acc_d  = '0;
          file_acc_d  = '0;
          hdr_pos_d   = '0;
          trl_pos_d   = '0;
          trl_match_d = 1'b1;
        end
      end
    end
  end

  // Walk state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q    <= RegionHeader;
      left_q      <= SizeBits'(HeaderLen);
      ofs_q       <= 2'd0;
      name_acc_q  <= '0;
      file_acc_q  <= '0;
      hdr_pos_q   <= '0;
      trl_pos_q   <= '0;
      trl_match_q <= 1'b1;
      entry_q     <= '0;
    end else if (accept) begin
      region_q    <= region_d;
      left_q      <= left_d;
      ofs_q       <= ofs_d;
      name_acc_q  <= name_acc_d;
      file_acc_q  <= file_acc_d;
      hdr_pos_q   <= hdr_pos_d;
      trl_pos_q   <= trl_pos_d;
      trl_match_q <= trl_match_d;
      entry_q     <= entry_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Output payload; the sizes are reported after this word's update.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q       <= archive_byte_i;
      region_out_q <= region_q;
      entry_out_q  <= EntryOutW'(entry_q);
      name_len_q   <= LengthW'(name_acc_d);
      data_len_q   <= LengthW'(file_acc_d);
      hdone_q      <= hdone;
      tfound_q     <= tfound;
      eend_q       <= eend;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_out_o      = byte_q;
  assign region_o        = region_out_q;
  assign entry_number_o  = entry_out_q;
  assign name_length_o   = name_len_q;
  assign data_length_o   = data_len_q;
  assign header_done_o   = hdone_q;
  assign trailer_found_o = tfound_q;
  assign entry_end_o     = eend_q;

  // Once the trailer is found the walk stays finished.
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    region_q == RegionDone |=> region_q == RegionDone)
    else $error("walker left the finished state");

  // The trailer is only recognized on a name word.
  a_trailer_in_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && tfound_q |-> region_out_q == RegionName)
    else $error("trailer flagged outside the name");

  // The header completes only on a header word.
  a_hdone_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && hdone_q |-> region_out_q == RegionHeader && !eend_q)
    else $error("header done flagged outside the header");

  // An entry end restarts the size accumulators.
  a_eend_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && eend_q |-> name_len_q == '0 && data_len_q == '0)
    else $error("sizes not cleared at entry end");

  // Every accepted word produces a result in the next cycle.
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted word produced no result");

endmodule
